### hdl/mfc_pkg.sv
// Shared types and constants for the multitouch frame classifier.
// Event codes, register indexes, seen-flag bits and the config/result structs.
// No dependencies.
package mfc_pkg;

    // Event types
    localparam logic [4:0] EV_SYN = 5'd0;
    localparam logic [4:0] EV_ABS = 5'd3;

    // Sync codes
    localparam logic [9:0] SYNC_FRAME   = 10'd0;
    localparam logic [9:0] SYNC_CONTACT = 10'd2;

    // Absolute axis codes
    localparam logic [9:0] AXIS_TOUCH_SIZE = 10'h030;
    localparam logic [9:0] AXIS_POS_X      = 10'h035;
    localparam logic [9:0] AXIS_POS_Y      = 10'h036;
    localparam logic [9:0] AXIS_TRACK_ID   = 10'h039;

    // Bit positions in the packet seen flags
    localparam int SEEN_X     = 0;
    localparam int SEEN_Y     = 1;
    localparam int SEEN_ANY   = 2;
    localparam int SEEN_SIZE  = 3;
    localparam int SEEN_TRACK = 4;

    // Register indexes (word address bits)
    localparam logic [2:0] REG_X_LOWER    = 3'd0;
    localparam logic [2:0] REG_X_UPPER    = 3'd1;
    localparam logic [2:0] REG_Y_LOWER    = 3'd2;
    localparam logic [2:0] REG_Y_UPPER    = 3'd3;
    localparam logic [2:0] REG_TRACKS_IDS = 3'd4;

    localparam int ADDR_W = 5;

    // Register reset values
    localparam logic [31:0] X_LOWER_RST = 32'd0;
    localparam logic [31:0] X_UPPER_RST = 32'd4095;
    localparam logic [31:0] Y_LOWER_RST = 32'd0;
    localparam logic [31:0] Y_UPPER_RST = 32'd4095;

    typedef enum logic [1:0] {
        KIND_POSITION   = 2'd0,
        KIND_INVALID    = 2'd1,
        KIND_MULTITOUCH = 2'd2,
        KIND_RELEASE    = 2'd3
    } frame_kind_t;

    typedef struct packed {
        logic signed [31:0] x_lower;
        logic signed [31:0] x_upper;
        logic signed [31:0] y_lower;
        logic signed [31:0] y_upper;
        logic               tracks_ids;
    } cfg_t;

    typedef struct packed {
        frame_kind_t        kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [7:0]         contact_count;
    } result_t;

endpackage

### hdl/mfc_apb_regs.sv
// APB configuration registers for the multitouch frame classifier.
// Holds the bounds window and the tracking-id enable; depends on mfc_pkg.
module mfc_apb_regs
    import mfc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_lower    <= X_LOWER_RST;
            cfg_reg.x_upper    <= X_UPPER_RST;
            cfg_reg.y_lower    <= Y_LOWER_RST;
            cfg_reg.y_upper    <= Y_UPPER_RST;
            cfg_reg.tracks_ids <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_X_LOWER:    cfg_reg.x_lower    <= pwdata;
                REG_X_UPPER:    cfg_reg.x_upper    <= pwdata;
                REG_Y_LOWER:    cfg_reg.y_lower    <= pwdata;
                REG_Y_UPPER:    cfg_reg.y_upper    <= pwdata;
                REG_TRACKS_IDS: cfg_reg.tracks_ids <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_X_LOWER:    prdata = cfg_reg.x_lower;
            REG_X_UPPER:    prdata = cfg_reg.x_upper;
            REG_Y_LOWER:    prdata = cfg_reg.y_lower;
            REG_Y_UPPER:    prdata = cfg_reg.y_upper;
            REG_TRACKS_IDS: prdata = {31'd0, cfg_reg.tracks_ids};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

### hdl/mfc_event_core.sv
// Event processing core: packet latches, contact cache, frame counters.
// Updates all tracking state for one event word per cycle while fire is high; depends on mfc_pkg.
module mfc_event_core
    import mfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic [4:0]         cmd,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    input  cfg_t               cfg,
    output logic               res_valid,
    output result_t            res
);

    logic signed [31:0] pkt_x_reg, pkt_x_next;
    logic signed [31:0] pkt_y_reg, pkt_y_next;
    logic signed [31:0] pkt_track_reg, pkt_track_next;
    logic               pkt_size_nz_reg, pkt_size_nz_next;
    logic [4:0]         pkt_seen_reg, pkt_seen_next;
    logic signed [31:0] cached_x_reg, cached_x_next;
    logic signed [31:0] cached_y_reg, cached_y_next;
    logic [1:0]         cached_valid_reg, cached_valid_next;
    logic               touch_active_reg, touch_active_next;
    logic signed [31:0] cur_track_reg, cur_track_next;
    logic               cur_track_valid_reg, cur_track_valid_next;
    logic [7:0]         frame_cnt_reg, frame_cnt_next;
    logic signed [31:0] frame_x_reg, frame_x_next;
    logic signed [31:0] frame_y_reg, frame_y_next;
    logic               frame_pos_valid_reg, frame_pos_valid_next;
    logic               pending_empty_reg, pending_empty_next;
    logic               is_contact;
    logic               in_bounds;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Bounds check on the frame position
    assign in_bounds = (frame_x_reg >= cfg.x_lower) && (frame_x_reg <= cfg.x_upper) &&
                       (frame_y_reg >= cfg.y_lower) && (frame_y_reg <= cfg.y_upper);

    // Next-state logic for one event word
    always_comb begin
        pkt_x_next           = pkt_x_reg;
        pkt_y_next           = pkt_y_reg;
        pkt_track_next       = pkt_track_reg;
        pkt_size_nz_next     = pkt_size_nz_reg;
        pkt_seen_next        = pkt_seen_reg;
        cached_x_next        = cached_x_reg;
        cached_y_next        = cached_y_reg;
        cached_valid_next    = cached_valid_reg;
        touch_active_next    = touch_active_reg;
        cur_track_next       = cur_track_reg;
        cur_track_valid_next = cur_track_valid_reg;
        frame_cnt_next       = frame_cnt_reg;
        frame_x_next         = frame_x_reg;
        frame_y_next         = frame_y_reg;
        frame_pos_valid_next = frame_pos_valid_reg;
        pending_empty_next   = pending_empty_reg;
        is_contact           = 1'b0;
        res_valid            = 1'b0;
        res.kind             = KIND_RELEASE;
        res.pos_x            = '0;
        res.pos_y            = '0;
        res.contact_count    = frame_cnt_reg;

        if (fire && cmd == EV_ABS) begin
            // Latch absolute axis values into the open packet
            pkt_seen_next[SEEN_ANY] = 1'b1;
            case (event_code)
                AXIS_POS_X: begin
                    pkt_x_next = event_value;
                    pkt_seen_next[SEEN_X] = 1'b1;
                end
                AXIS_POS_Y: begin
                    pkt_y_next = event_value;
                    pkt_seen_next[SEEN_Y] = 1'b1;
                end
                AXIS_TOUCH_SIZE: begin
                    pkt_size_nz_next = (event_value != 32'sd0);
                    pkt_seen_next[SEEN_SIZE] = 1'b1;
                end
                AXIS_TRACK_ID: begin
                    pkt_track_next = event_value;
                    pkt_seen_next[SEEN_TRACK] = 1'b1;
                end
                default: ;
            endcase
        end else if (fire && cmd == EV_SYN && event_code == SYNC_CONTACT) begin
            // Close the packet and decide whether it is a contact
            is_contact = pkt_seen_reg[SEEN_ANY];
            if (pkt_seen_reg[SEEN_SIZE] && !pkt_size_nz_reg) begin
                is_contact = 1'b0;
            end
            if (cfg.tracks_ids && pkt_seen_reg[SEEN_TRACK] && pkt_track_reg[31]) begin
                is_contact = 1'b0;
            end
            if (is_contact) begin
                // Replay the cached contact after an empty packet
                if (pending_empty_reg) begin
                    frame_cnt_next = sat_inc(frame_cnt_next);
                    if (frame_cnt_next == 8'd1 && cached_valid_next == 2'b11) begin
                        frame_x_next         = cached_x_next;
                        frame_y_next         = cached_y_next;
                        frame_pos_valid_next = 1'b1;
                    end
                    pending_empty_next = 1'b0;
                end
                // Drop the cache when the tracking id changes
                if (cfg.tracks_ids && pkt_seen_reg[SEEN_TRACK]) begin
                    if (!cur_track_valid_reg || pkt_track_reg != cur_track_reg) begin
                        cached_valid_next = 2'b00;
                    end
                    cur_track_next       = pkt_track_reg;
                    cur_track_valid_next = 1'b1;
                end
                if (pkt_seen_reg[SEEN_X]) begin
                    cached_x_next        = pkt_x_reg;
                    cached_valid_next[0] = 1'b1;
                end
                if (pkt_seen_reg[SEEN_Y]) begin
                    cached_y_next        = pkt_y_reg;
                    cached_valid_next[1] = 1'b1;
                end
                frame_cnt_next = sat_inc(frame_cnt_next);
                if (frame_cnt_next == 8'd1 && cached_valid_next == 2'b11) begin
                    frame_x_next         = cached_x_next;
                    frame_y_next         = cached_y_next;
                    frame_pos_valid_next = 1'b1;
                end
            end else if (touch_active_reg) begin
                pending_empty_next = 1'b1;
            end
            pkt_seen_next = '0;
        end else if (fire && cmd == EV_SYN && event_code == SYNC_FRAME) begin
            // Classify the frame and emit one result word
            res_valid = 1'b1;
            if (frame_cnt_reg == 8'd1) begin
                touch_active_next = 1'b1;
                if (frame_pos_valid_reg && in_bounds) begin
                    res.kind  = KIND_POSITION;
                    res.pos_x = frame_x_reg;
                    res.pos_y = frame_y_reg;
                end else begin
                    res.kind = KIND_INVALID;
                end
            end else if (frame_cnt_reg > 8'd1) begin
                touch_active_next = 1'b1;
                res.kind          = KIND_MULTITOUCH;
            end else begin
                res.kind             = KIND_RELEASE;
                cached_valid_next    = 2'b00;
                touch_active_next    = 1'b0;
                cur_track_valid_next = 1'b0;
            end
            frame_cnt_next       = 8'd0;
            frame_pos_valid_next = 1'b0;
            pending_empty_next   = 1'b0;
            pkt_seen_next        = '0;
        end
    end

    // Hold tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_x_reg           <= '0;
            pkt_y_reg           <= '0;
            pkt_track_reg       <= '0;
            pkt_size_nz_reg     <= 1'b0;
            pkt_seen_reg        <= '0;
            cached_x_reg        <= '0;
            cached_y_reg        <= '0;
            cached_valid_reg    <= '0;
            touch_active_reg    <= 1'b0;
            cur_track_reg       <= '0;
            cur_track_valid_reg <= 1'b0;
            frame_cnt_reg       <= '0;
            frame_x_reg         <= '0;
            frame_y_reg         <= '0;
            frame_pos_valid_reg <= 1'b0;
            pending_empty_reg   <= 1'b0;
        end else begin
            pkt_x_reg           <= pkt_x_next;
            pkt_y_reg           <= pkt_y_next;
            pkt_track_reg       <= pkt_track_next;
            pkt_size_nz_reg     <= pkt_size_nz_next;
            pkt_seen_reg        <= pkt_seen_next;
            cached_x_reg        <= cached_x_next;
            cached_y_reg        <= cached_y_next;
            cached_valid_reg    <= cached_valid_next;
            touch_active_reg    <= touch_active_next;
            cur_track_reg       <= cur_track_next;
            cur_track_valid_reg <= cur_track_valid_next;
            frame_cnt_reg       <= frame_cnt_next;
            frame_x_reg         <= frame_x_next;
            frame_y_reg         <= frame_y_next;
            frame_pos_valid_reg <= frame_pos_valid_next;
            pending_empty_reg   <= pending_empty_next;
        end
    end

endmodule

### hdl/mfc_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Keeps m_ready off the combinational path to the input side; depends on mfc_pkg.
module mfc_out_buf
    import mfc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop     = out_valid_reg & m_ready;
    assign room    = ~skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: advance skid into the output slot, park new words behind it
    always_ff @(posedge aclk) begin
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

### hdl/multitouch_frame_classifier_top.sv
// Multitouch frame classifier, top level.
// Path of a frame sync word: input register, event core, result buffer register, then m_*.
// Throughput: one event word per cycle while the result buffer has room.
// Reset: aresetn (synchronous, active low) clears all tracking state and restores
// the register defaults (bounds 0..4095, tracking ids off).
// Depends on mfc_pkg, mfc_apb_regs, mfc_event_core and mfc_out_buf.
module multitouch_frame_classifier_top
    import mfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Event input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_cmd,
    input  logic [9:0]         s_event_code,
    input  logic signed [31:0] s_event_value,
    // Result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_frame_kind,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [7:0]         m_contact_count
);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic [4:0]         in_cmd_reg;
    logic [9:0]         in_code_reg;
    logic signed [31:0] in_value_reg;
    logic               out_room;
    logic               fire;
    logic               res_valid;
    result_t            res;
    result_t            m_data;

    mfc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Process the registered word whenever the result buffer has room
    assign fire    = in_valid_reg & out_room;
    assign s_ready = ~in_valid_reg | out_room;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg   <= s_cmd;
            in_code_reg  <= s_event_code;
            in_value_reg <= s_event_value;
        end
    end

    mfc_event_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .cmd         (in_cmd_reg),
        .event_code  (in_code_reg),
        .event_value (in_value_reg),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    mfc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire & res_valid),
        .push_data (res),
        .room      (out_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_frame_kind    = m_data.kind;
    assign m_pos_x         = m_data.pos_x;
    assign m_pos_y         = m_data.pos_y;
    assign m_contact_count = m_data.contact_count;

endmodule
